[hdl/swa_pkg.sv]
// Package for the sliding window admission unit.
// Holds field widths, register indexes and the structs used by the design files.
// No dependencies.
`default_nettype none

package swa_pkg;

  localparam int AMT_W  = 32;  // request amount
  localparam int SUM_W  = 40;  // window sum and limit
  localparam int LEN_W  = 9;   // window_length register
  localparam int DATA_W = 64;  // configuration data bus
  localparam int ADDR_W = 4;   // byte address, registers at 8*i

  // Register index, taken from paddr[3].
  typedef enum logic {
    REG_WINDOW_LENGTH = 1'b0,
    REG_LIMIT         = 1'b1
  } swa_reg_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic             clear;  // window_length written this cycle
    logic [SUM_W-1:0] limit;
  } swa_cfg_t;

  // Control broadcast to every cell of the ring.
  typedef struct packed {
    logic clear;
    logic shift;
  } swa_cell_ctl_t;

endpackage

`default_nettype wire

[hdl/swa_in_if.sv]
// Request channel: valid/ready handshake carrying one amount word.
// Uses swa_pkg for the field width.
`default_nettype none

interface swa_in_if;
  logic                        valid;
  logic                        ready;
  logic [swa_pkg::AMT_W-1:0]   amount;

  modport source (output valid, output amount, input ready);
  modport sink (input valid, input amount, output ready);
endinterface

`default_nettype wire

[hdl/swa_out_if.sv]
// Response channel: valid/ready handshake carrying the admission decision.
// No dependencies.
`default_nettype none

interface swa_out_if;
  logic valid;
  logic ready;
  logic accepted;

  modport source (output valid, output accepted, input ready);
  modport sink (input valid, input accepted, output ready);
endinterface

`default_nettype wire

[hdl/swa_cfg.sv]
// APB-style configuration registers: window_length and limit.
// Derives the index of the last ring cell from window_length. Uses swa_pkg.
`default_nettype none

module swa_cfg #(
  parameter int WINDOW_MAX = 256,
  parameter int LW = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [swa_pkg::ADDR_W-1:0] paddr,
  input  wire logic [swa_pkg::DATA_W-1:0] pwdata,
  output logic      [swa_pkg::DATA_W-1:0] prdata,
  output logic                            pready,
  output swa_pkg::swa_cfg_t               cfg,
  output logic      [LW-1:0]              last_idx
);

  logic [swa_pkg::LEN_W-1:0] window_length;
  logic [swa_pkg::SUM_W-1:0] limit;
  logic [LW-1:0]             last_idx_next;
  logic                      wr;
  swa_pkg::swa_reg_t         reg_sel;
  logic [swa_pkg::LEN_W-1:0] wl_new;
  logic [31:0]               wl_wide;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite && pready;
  assign reg_sel = swa_pkg::swa_reg_t'(paddr[3]);
  assign wl_new  = pwdata[swa_pkg::LEN_W-1:0];
  assign wl_wide = 32'(wl_new);

  // Zero acts as one, anything beyond the ring saturates to the ring size.
  always_comb begin
    priority if (wl_new == '0) begin
      last_idx_next = '0;
    end else if (wl_wide > 32'(WINDOW_MAX)) begin
      last_idx_next = LW'(WINDOW_MAX - 1);
    end else begin
      last_idx_next = LW'(wl_wide - 32'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= swa_pkg::LEN_W'(1);
      limit         <= '0;
      last_idx      <= '0;
    end else if (wr) begin
      unique case (reg_sel)
        swa_pkg::REG_WINDOW_LENGTH: begin
          window_length <= wl_new;
          last_idx      <= last_idx_next;
        end
        swa_pkg::REG_LIMIT: begin
          limit <= pwdata[swa_pkg::SUM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      swa_pkg::REG_WINDOW_LENGTH: prdata = swa_pkg::DATA_W'(window_length);
      swa_pkg::REG_LIMIT:         prdata = swa_pkg::DATA_W'(limit);
      default:                    prdata = '0;
    endcase
  end

  assign cfg.clear = wr && (reg_sel == swa_pkg::REG_WINDOW_LENGTH);
  assign cfg.limit = limit;

endmodule

`default_nettype wire

[hdl/swa_cell.sv]
// One cell of the amount ring: holds one admitted amount word.
// Takes its neighbor's word on each step, or the new word when it is the last cell.
// Uses swa_pkg.
`default_nettype none

module swa_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire swa_pkg::swa_cell_ctl_t    ctl,
  input  wire logic                      is_last,
  input  wire logic [swa_pkg::AMT_W-1:0] ins_val,
  input  wire logic [swa_pkg::AMT_W-1:0] nbr_val,
  output logic      [swa_pkg::AMT_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      q <= '0;
    end else if (ctl.shift) begin
      q <= is_last ? ins_val : nbr_val;
    end
  end

endmodule

`default_nettype wire

[hdl/sliding_window_admission_unit.sv]
// Sliding window admission unit: admits a request while the admitted total
// over the last window_length requests stays within limit.
// Depends on swa_pkg, swa_in_if, swa_out_if, swa_cfg and swa_cell.
//
// Usage:
//   req carries one 32-bit amount per word; rsp returns one word with the
//   accepted bit for each request, in order.
//   rsp.valid rises in the cycle after request acceptance. One request
//   is taken every cycle unless a response is stalled; the feedback loop
//   is the window sum update (subtract leaving amount, add new amount,
//   compare with limit). The ring is a row of WINDOW_MAX cells. New words
//   enter at cell window_length - 1 (clamped to the ring) and move one cell
//   toward cell 0 per request; cell 0 holds the amount leaving the window.
//   The response register frees itself when rsp.ready is high, so req.ready
//   drops only while a response is held by a stalled receiver.
//   Reset clears the ring and the sum, sets window_length to 1 and limit
//   to 0. Writing window_length clears the ring and the sum in the
//   same cycle; write configuration only while no request is in flight.
//   Registers: window_length at byte 0, limit at byte 8 (64-bit data).
`default_nettype none

module sliding_window_admission_unit #(
  parameter int WINDOW_MAX = 256
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  swa_in_if.sink                          req,
  swa_out_if.source                       rsp,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [swa_pkg::ADDR_W-1:0] paddr,
  input  wire logic [swa_pkg::DATA_W-1:0] pwdata,
  output logic      [swa_pkg::DATA_W-1:0] prdata,
  output logic                            pready
);

  localparam int LW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  swa_pkg::swa_cfg_t         cfg;
  swa_pkg::swa_cell_ctl_t    cell_ctl;
  logic [LW-1:0]             last_idx;
  logic [swa_pkg::AMT_W-1:0] cell_q [WINDOW_MAX];

  logic [swa_pkg::SUM_W-1:0] window_sum;
  logic [swa_pkg::SUM_W-1:0] window_sum_next;
  logic [swa_pkg::SUM_W-1:0] sum_rest;
  logic [swa_pkg::SUM_W:0]   sum_test;
  logic                      admit;
  logic [swa_pkg::AMT_W-1:0] stored;
  logic                      step;
  logic                      rsp_valid;
  logic                      rsp_accepted;

  swa_cfg #(
    .WINDOW_MAX (WINDOW_MAX),
    .LW         (LW)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .cfg      (cfg),
    .last_idx (last_idx)
  );

  assign req.ready = !rsp_valid || rsp.ready;
  assign step      = req.valid && req.ready;

  // Cell 0 holds the amount stored window_length requests ago.
  assign sum_rest = window_sum - swa_pkg::SUM_W'(cell_q[0]);
  assign sum_test = {1'b0, sum_rest} + (swa_pkg::SUM_W + 1)'(req.amount);
  assign admit    = sum_test <= {1'b0, cfg.limit};
  assign stored   = admit ? req.amount : '0;
  assign window_sum_next = sum_test[swa_pkg::SUM_W-1:0];

  assign cell_ctl.clear = cfg.clear;
  assign cell_ctl.shift = step;

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    logic [swa_pkg::AMT_W-1:0] nbr;
    if (i == WINDOW_MAX - 1) begin : g_end
      assign nbr = '0;
    end else begin : g_mid
      assign nbr = cell_q[i+1];
    end
    swa_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (cell_ctl),
      .is_last (last_idx == LW'(i)),
      .ins_val (stored),
      .nbr_val (nbr),
      .q       (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      window_sum <= '0;
    end else if (step) begin
      window_sum <= admit ? window_sum_next : sum_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (step) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      rsp_accepted <= admit;
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.accepted = rsp_accepted;

  // A rejected request never grows the window sum.
  a_reject_no_growth: assert property (@(posedge clk) disable iff (rst)
    step && !admit && !cfg.clear |=> window_sum <= $past(window_sum))
    else $error("window sum grew on a rejected request");

  // Writing window_length empties the window.
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cfg.clear |=> window_sum == '0 && cell_q[0] == '0)
    else $error("window not cleared after window_length write");

  // Every accepted request leaves a response pending.
  a_step_response: assert property (@(posedge clk) disable iff (rst)
    step |=> rsp_valid)
    else $error("request accepted without a response");

  // Requests are held off only by a stalled response.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> rsp_valid && !rsp.ready)
    else $error("request path stalled without a held response");

endmodule

`default_nettype wire

[bench/sliding_window_admission_unit_tb.sv]
// Testbench for the sliding window admission unit: drives request words and
// register writes, predicts every admission decision and checks each response.
// Depends on swa_pkg, swa_in_if, swa_out_if and the unit itself.
`timescale 1ns / 1ps

module sliding_window_admission_unit_tb;

  localparam int RING_DEPTH = 256;
  localparam longint unsigned LIMIT_MAX = (64'd1 << swa_pkg::SUM_W) - 64'd1;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [swa_pkg::ADDR_W-1:0] paddr;
  logic [swa_pkg::DATA_W-1:0] pwdata;
  logic [swa_pkg::DATA_W-1:0] prdata;
  logic pready;

  swa_in_if  req();
  swa_out_if rsp();

  sliding_window_admission_unit #(.WINDOW_MAX(RING_DEPTH)) u_dut (
    .clk(clk), .rst(rst), .req(req), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  // Shadow of the unit: registers, admitted amounts per slot, running total.
  logic [swa_pkg::LEN_W-1:0] win_len_reg;
  logic [swa_pkg::SUM_W-1:0] limit_reg;
  logic [swa_pkg::AMT_W-1:0] admitted_amt [RING_DEPTH];
  int unsigned               cur_slot;
  logic [swa_pkg::SUM_W-1:0] admitted_total;

  logic pending_verdicts [$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  function automatic int unsigned eff_window();
    int unsigned wl;
    wl = int'(win_len_reg);
    if (wl == 0) return 1;
    if (wl > RING_DEPTH) return RING_DEPTH;
    return wl;
  endfunction

  function automatic void clear_window();
    foreach (admitted_amt[i]) admitted_amt[i] = '0;
    cur_slot = 0;
    admitted_total = '0;
  endfunction

  // Drops the amount leaving the window, then admits the new one if the
  // total stays within the limit. The trial sum carries one extra bit.
  function automatic logic admit_request(input logic [swa_pkg::AMT_W-1:0] amt);
    int unsigned len;
    logic [swa_pkg::SUM_W:0] trial;
    logic ok;
    len = eff_window();
    if (cur_slot >= len) cur_slot = 0;
    admitted_total = admitted_total - swa_pkg::SUM_W'(admitted_amt[cur_slot]);
    trial = {1'b0, admitted_total} + (swa_pkg::SUM_W + 1)'(amt);
    ok = (trial <= {1'b0, limit_reg});
    if (ok) begin
      admitted_total = trial[swa_pkg::SUM_W-1:0];
      admitted_amt[cur_slot] = amt;
    end else begin
      admitted_amt[cur_slot] = '0;
    end
    cur_slot = (cur_slot + 1 >= len) ? 0 : cur_slot + 1;
    return ok;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  // Responses are checked before the request taken at the same edge is
  // predicted; a response always belongs to an earlier request.
  always @(posedge clk) begin : check_decisions
    logic want;
    if (!rst) begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (pending_verdicts.size() == 0) begin
          report_mismatch("response word with no request pending");
        end else begin
          want = pending_verdicts.pop_front();
          if (rsp.accepted !== want)
            report_mismatch($sformatf("accepted is %b, expected %b", rsp.accepted, want));
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1)
        pending_verdicts.push_back(admit_request(req.amount));
    end
  end

  always @(negedge clk) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic send_amount(input logic [swa_pkg::AMT_W-1:0] amt);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.amount <= amt;
    do @(posedge clk); while (req.ready !== 1'b1);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    do @(negedge clk); while (pending_verdicts.size() != 0);
  endtask

  task automatic write_reg(input swa_pkg::swa_reg_t idx,
                           input logic [swa_pkg::DATA_W-1:0] value);
    logic [swa_pkg::ADDR_W-1:0] addr;
    addr = '0;
    addr[swa_pkg::ADDR_W-1] = idx;
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      swa_pkg::REG_WINDOW_LENGTH: begin
        win_len_reg = value[swa_pkg::LEN_W-1:0];
        clear_window();
      end
      swa_pkg::REG_LIMIT: limit_reg = value[swa_pkg::SUM_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic [swa_pkg::AMT_W-1:0] draw_amount(
    input logic [swa_pkg::AMT_W-1:0] cap);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 8) return $urandom;
    if (pick < 12) return '0;
    if (pick < 16) return cap;
    return $urandom_range(cap, 0);
  endfunction

  // Window of one and limit zero straight out of reset.
  task automatic test_reset_state();
    send_amount(32'd0);
    send_amount(32'd1);
    send_amount(32'hFFFF_FFFF);
  endtask

  // A window length of zero behaves as one; then a window of two.
  task automatic test_short_windows();
    write_reg(swa_pkg::REG_WINDOW_LENGTH, 64'd0);
    write_reg(swa_pkg::REG_LIMIT, 64'd5);
    send_amount(32'd5);
    send_amount(32'd5);
    send_amount(32'd6);
    write_reg(swa_pkg::REG_WINDOW_LENGTH, 64'd2);
    write_reg(swa_pkg::REG_LIMIT, 64'd10);
    send_amount(32'd6);
    send_amount(32'd5);
    send_amount(32'd4);
    send_amount(32'd6);
  endtask

  // A new limit applies to the next word and keeps the admitted history.
  task automatic test_limit_keeps_window();
    write_reg(swa_pkg::REG_LIMIT, 64'd3);
    send_amount(32'd3);
    send_amount(32'd3);
  endtask

  // Lengths above the ring depth saturate; upper data bits are dropped.
  task automatic test_saturated_window();
    write_reg(swa_pkg::REG_WINDOW_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(swa_pkg::REG_LIMIT, 64'h1_FFFF_FFFE);
    send_amount(32'hFFFF_FFFF);
    send_amount(32'hFFFF_FFFF);
    send_amount(32'd1);
    send_amount(32'd0);
    write_reg(swa_pkg::REG_LIMIT, 64'hFFFF_FFFF_FFFF_FFFF);
    send_amount(32'hFFFF_FFFF);
    send_amount(32'hFFFF_FFFF);
  endtask

  // A single request larger than the limit is refused.
  task automatic test_amount_over_limit();
    write_reg(swa_pkg::REG_WINDOW_LENGTH, 64'd1);
    write_reg(swa_pkg::REG_LIMIT, 64'hFFFF_FFFE);
    send_amount(32'hFFFF_FFFF);
    send_amount(32'hFFFF_FFFE);
  endtask

  // Segments of random words, each under a fresh limit and mostly a fresh window. The limit
  // is scaled to the window and amount range so both decisions are common.
  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned done_items, seg_items, kind, len, amt_cap, i;
    longint unsigned lim;
    logic [swa_pkg::DATA_W-1:0] wdata;
    done_items = 0;
    while (done_items < n_items) begin
      kind = $urandom_range(9);
      if (kind != 9) begin
        case (kind)
          6: len = $urandom_range(1);
          7: len = $urandom_range(255, 17);
          8: len = $urandom_range(1) ? RING_DEPTH : $urandom_range(511, 257);
          default: len = $urandom_range(16, 1);
        endcase
        wdata = {$urandom, $urandom};
        wdata[swa_pkg::LEN_W-1:0] = len[swa_pkg::LEN_W-1:0];
        write_reg(swa_pkg::REG_WINDOW_LENGTH, wdata);
      end
      case ($urandom_range(2))
        0: amt_cap = $urandom_range(255, 1);
        1: amt_cap = $urandom_range(65535, 256);
        default: amt_cap = 32'hFFFF_FFFF;
      endcase
      lim = longint'(amt_cap) * longint'(eff_window())
            * longint'($urandom_range(3, 1)) / 64'd2;
      if (lim > LIMIT_MAX) lim = LIMIT_MAX;
      case ($urandom_range(7))
        0: lim = 0;
        1: lim = LIMIT_MAX;
        default: ;
      endcase
      wdata = {$urandom, $urandom};
      wdata[swa_pkg::SUM_W-1:0] = lim[swa_pkg::SUM_W-1:0];
      write_reg(swa_pkg::REG_LIMIT, wdata);
      seg_items = (eff_window() >= 128) ? $urandom_range(400, 280) : $urandom_range(80, 20);
      for (i = 0; i < seg_items && done_items < n_items; i++) begin
        if ($urandom_range(59) == 0) wait_drained();
        send_amount(draw_amount(amt_cap));
        done_items++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.amount = '0;
    rsp.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    win_len_reg = swa_pkg::LEN_W'(1);
    limit_reg = '0;
    clear_window();
    send_idle_pct = 25;
    recv_idle_pct = 49;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_short_windows();
    test_limit_keeps_window();
    test_saturated_window();
    test_amount_over_limit();
    test_random_traffic(545);
    send_idle_pct = 49;
    recv_idle_pct = 25;
    test_random_traffic(545);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(545);

    wait_drained();
    repeat (4) @(negedge clk);
    if (mismatches == 0) begin
      $display("[sliding_window_admission_unit] OK");
    end else begin
      $display("[sliding_window_admission_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[sliding_window_admission_unit] ERROR");
    $finish;
  end

endmodule

[sliding_window_admission_unit.f]
hdl/swa_pkg.sv
hdl/swa_in_if.sv
hdl/swa_out_if.sv
hdl/swa_cfg.sv
hdl/swa_cell.sv
hdl/sliding_window_admission_unit.sv
bench/sliding_window_admission_unit_tb.sv
